@@ hw/rtl/pip_pkg.sv @@
// Shared types and constants of the point-in-polygon test block.
package pip_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int INDEX_WIDTH = 8;
	localparam int COUNT_WIDTH = 9;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEST = 1'b1;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
	} pip_vtx_t;

	typedef struct packed {
		logic clr;
		logic vld;
	} pip_edge_ctl_t;

endpackage

@@ hw/rtl/pip_if.sv @@
// Request and response channel interfaces of the point-in-polygon test block.
interface pip_req_if;
	import pip_pkg::*;

	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [INDEX_WIDTH-1:0]        vertex_index;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;

	modport source (output valid, output operation, output vertex_index,
		output coord_x, output coord_y, input ready);
	modport sink (input valid, input operation, input vertex_index,
		input coord_x, input coord_y, output ready);
endinterface

interface pip_rsp_if;
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, output inside_res, input ready);
	modport sink (input valid, input inside_res, output ready);
endinterface

@@ hw/rtl/pip_cell.sv @@
// One vertex cell of the rotating vertex ring.
module pip_cell (
	input  logic              clk,
	input  logic              shift_en,
	input  logic              load_en,
	input  pip_pkg::pip_vtx_t load_vtx,
	input  pip_pkg::pip_vtx_t nbr_vtx,
	output pip_pkg::pip_vtx_t vtx
);
	import pip_pkg::*;

	pip_vtx_t vtx_q;

	always_ff @(posedge clk) begin
		if (load_en) begin
			vtx_q <= load_vtx;
		end else if (shift_en) begin
			vtx_q <= nbr_vtx;
		end
	end

	assign vtx = vtx_q;

endmodule

@@ hw/rtl/pip_edge.sv @@
// Edge crossing pipeline that toggles the inside flag with an exact cross product.
module pip_edge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pip_pkg::pip_edge_ctl_t        ctl,
	input  logic signed [pip_pkg::COORD_WIDTH-1:0] tx,
	input  logic signed [pip_pkg::COORD_WIDTH-1:0] ty,
	input  pip_pkg::pip_vtx_t             vtx_i,
	input  pip_pkg::pip_vtx_t             vtx_j,
	output logic                          flag,
	output logic                          busy
);
	import pip_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;

	logic                 vld_s1;
	logic                 dypos_s1;
	logic signed [DW-1:0] dy_s1;
	logic signed [DW-1:0] a_s1;
	logic signed [DW-1:0] b_s1;
	logic signed [DW-1:0] c_s1;
	logic                 vld_s2;
	logic                 dypos_s2;
	logic signed [PW-1:0] p1_s2;
	logic signed [PW-1:0] p2_s2;
	logic                 flag_q;
	logic                 straddle;
	logic signed [DW-1:0] dy;
	logic signed [PW-1:0] p1;
	logic signed [PW-1:0] p2;
	logic                 toggle;

	assign straddle = (vtx_i.y > ty) != (vtx_j.y > ty);
	assign dy       = DW'(vtx_j.y) - DW'(vtx_i.y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			flag_q <= 1'b0;
		end else begin
			vld_s1 <= ctl.vld && straddle;
			vld_s2 <= vld_s1;
			if (ctl.clr) begin
				flag_q <= 1'b0;
			end else begin
				flag_q <= flag_q ^ toggle;
			end
		end
	end

	always_ff @(posedge clk) begin
		dy_s1    <= dy;
		dypos_s1 <= !dy[DW-1];
		a_s1     <= DW'(tx) - DW'(vtx_i.x);
		b_s1     <= DW'(vtx_j.x) - DW'(vtx_i.x);
		c_s1     <= DW'(ty) - DW'(vtx_i.y);
		p1_s2    <= p1;
		p2_s2    <= p2;
		dypos_s2 <= dypos_s1;
	end

	assign p1 = a_s1 * dy_s1;
	assign p2 = b_s1 * c_s1;

	// A straddling edge never has a zero height, so the sign bit decides the direction.
	assign toggle = vld_s2 && (dypos_s2 ? (p1_s2 < p2_s2) : (p1_s2 > p2_s2));

	assign flag = flag_q;
	assign busy = vld_s1 || vld_s2;

endmodule

@@ hw/rtl/point_in_polygon_test.sv @@
// Top level of the point-in-polygon test block.
//
//   channel  direction  fields
//   req      in         operation, vertex_index, coord_x, coord_y
//   rsp      out        inside_res
//   cfg      in         cfg_we, cfg_wdata (vertex_count)
//
// A load request writes the vertex cell at vertex_index. A test request rotates the vertex
// ring once past the edge pipeline, then drains it.
// The response is valid in the cycle after the drain ends.
// A test with a vertex count of zero or above MAX_VERTICES skips the walk and enters the drain.
// Reset clears the control state and the vertex count; vertex contents stay undefined.
// A waiting response does not block loads, and a finished test holds until it is taken.
module point_in_polygon_test #(
	parameter int MAX_VERTICES = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pip_pkg::COUNT_WIDTH-1:0] cfg_wdata,
	pip_req_if.sink                         req,
	pip_rsp_if.source                       rsp
);
	import pip_pkg::*;

	localparam int SW = $clog2(MAX_VERTICES + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]                    state_q;
	logic [SW-1:0]                 step_q;
	logic [COUNT_WIDTH-1:0]        vertex_count_q;
	logic signed [COORD_WIDTH-1:0] tx_q;
	logic signed [COORD_WIDTH-1:0] ty_q;
	pip_vtx_t                      first_q;
	pip_vtx_t                      prev_q;
	logic                          rsp_valid_q;
	logic                          rsp_res_q;

	pip_vtx_t      ring [MAX_VERTICES];
	pip_vtx_t      load_vtx;
	pip_vtx_t      cur_vtx;
	pip_edge_ctl_t edge_ctl;
	logic          req_fire;
	logic          is_load;
	logic          shift_en;
	logic          count_ok;
	logic          flag;
	logic          edge_busy;
	logic          out_free;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign is_load   = req_fire && (req.operation == OP_LOAD);
	assign load_vtx  = '{x: req.coord_x, y: req.coord_y};
	assign shift_en  = (state_q == ST_RUN) && (32'(step_q) < MAX_VERTICES);
	assign count_ok  = (vertex_count_q != '0) && (32'(vertex_count_q) <= MAX_VERTICES);
	assign out_free  = !rsp_valid_q || rsp.ready;

	for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
		pip_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.load_en  (is_load && (32'(req.vertex_index) == k)),
			.load_vtx (load_vtx),
			.nbr_vtx  (ring[(k + 1) % MAX_VERTICES]),
			.vtx      (ring[k])
		);
	end

	// The closing edge pairs the last vertex with the first one.
	assign cur_vtx = (32'(step_q) == 32'(vertex_count_q)) ? first_q : ring[0];

	assign edge_ctl.clr = req_fire && (req.operation == OP_TEST);
	assign edge_ctl.vld = (state_q == ST_RUN) && (step_q != '0) &&
		(32'(step_q) <= 32'(vertex_count_q));

	pip_edge u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (edge_ctl),
		.tx     (tx_q),
		.ty     (ty_q),
		.vtx_i  (cur_vtx),
		.vtx_j  (prev_q),
		.flag   (flag),
		.busy   (edge_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			step_q         <= '0;
			vertex_count_q <= '0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				vertex_count_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire && (req.operation == OP_TEST)) begin
						step_q  <= '0;
						state_q <= count_ok ? ST_RUN : ST_DRAIN;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (32'(step_q) == MAX_VERTICES) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!edge_busy && out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			tx_q <= req.coord_x;
			ty_q <= req.coord_y;
		end
		if (state_q == ST_RUN) begin
			prev_q <= ring[0];
			if (step_q == '0) begin
				first_q <= ring[0];
			end
		end
		if ((state_q == ST_DRAIN) && !edge_busy && out_free) begin
			rsp_res_q <= flag;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.inside_res = rsp_res_q;

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (32'(step_q) <= MAX_VERTICES))
		else $error("ring step counter ran past the ring length");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !edge_busy)
		else $error("edge pipeline still busy while idle");

	a_test_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && (req.operation == OP_TEST)) |=> (state_q != ST_IDLE))
		else $error("test request did not start a walk");

	a_rsp_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_DRAIN))
		else $error("response raised outside the drain state");

endmodule
